### sv/ehss_pkg.sv
// Shared types, constants and codes of the encoder homing stroke sequencer.
package ehss_pkg;

  localparam int QueueDepth = 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int PosW     = 16;
  localparam int OffsetW  = 15;
  localparam int SpeedW   = 8;
  localparam int PauseW   = 16;

  localparam logic [OffsetW-1:0] HomeOffsetReset    = 15'd200;
  localparam logic [OffsetW-1:0] StrokeLimitReset   = 15'd1440;
  localparam logic [SpeedW-1:0]  ForwardSpeedReset  = 8'd90;
  localparam logic [SpeedW-1:0]  BackwardSpeedReset = 8'd80;
  localparam logic [PauseW-1:0]  PauseTicksReset    = 16'd200;

  localparam logic signed [PosW-1:0] PosMax = 16'sh7FFF;
  localparam logic signed [PosW-1:0] PosMin = -16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOME_OFFSET    = 3'd0,
    CFG_STROKE_LIMIT   = 3'd1,
    CFG_FORWARD_SPEED  = 3'd2,
    CFG_BACKWARD_SPEED = 3'd3,
    CFG_PAUSE_TICKS    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_RELEASE  = 2'd0,
    CMD_FORWARD  = 2'd1,
    CMD_BACKWARD = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    PH_SEEK       = 3'd0,
    PH_TO_START   = 3'd1,
    PH_HOME_PAUSE = 3'd2,
    PH_FORWARD    = 3'd3,
    PH_FWD_PAUSE  = 3'd4,
    PH_BACKWARD   = 3'd5,
    PH_BWD_PAUSE  = 3'd6
  } phase_e;

  // One classified sample tick.
  typedef struct packed {
    logic edge_up;
    logic edge_down;
    logic index_hit;
  } ev_t;

  typedef struct packed {
    logic [OffsetW-1:0] home_offset;
    logic [OffsetW-1:0] stroke_limit;
    logic [SpeedW-1:0]  forward_speed;
    logic [SpeedW-1:0]  backward_speed;
    logic [PauseW-1:0]  pause_ticks;
  } cfg_t;

endpackage

### sv/ehss_front.sv
// Front end: accepts sample items and classifies encoder edges.
module ehss_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            chan_a_i,
  input  logic            chan_b_i,
  input  logic            index_pin_i,
  input  logic            q_full_i,
  output logic            push_o,
  output ehss_pkg::ev_t   ev_o
);

  logic last_a_q, last_a_d;
  logic rise;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // A rising edge of channel A counts up with B low and down with B high.
  assign rise          = !last_a_q && chan_a_i;
  assign ev_o.edge_up   = rise && !chan_b_i;
  assign ev_o.edge_down = rise && chan_b_i;
  assign ev_o.index_hit = index_pin_i;

  assign last_a_d = push_o ? chan_a_i : last_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q <= 1'b0;
    end else begin
      last_a_q <= last_a_d;
    end
  end

endmodule

### sv/ehss_queue.sv
// Small flop-based FIFO of classified items between front and back.
module ehss_queue #(
  parameter int Depth = ehss_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ehss_pkg::ev_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output ehss_pkg::ev_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ehss_pkg::ev_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/ehss_back.sv
// Back end: position counter, homing and stroke sequencer, output register.
module ehss_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ehss_pkg::cfg_t                      cfg_i,
  input  logic                                q_valid_i,
  input  ehss_pkg::ev_t                       ev_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          motor_cmd_o,
  output logic [ehss_pkg::SpeedW-1:0]         motor_speed_o,
  output logic signed [ehss_pkg::PosW-1:0]    position_o,
  output logic [2:0]                          phase_o
);

  logic signed [ehss_pkg::PosW-1:0] count_q, count_d, count_e;
  logic [ehss_pkg::PauseW-1:0]      pause_q, pause_d;
  ehss_pkg::phase_e                 phase_q, phase_d;
  logic                             out_valid_q, out_valid_d;
  ehss_pkg::cmd_e                   cmd_d;
  logic [ehss_pkg::SpeedW-1:0]      speed_d;
  logic                             pause_done;
  logic signed [ehss_pkg::PosW-1:0] home_s, limit_s;

  ehss_pkg::cmd_e                   cmd_q;
  logic [ehss_pkg::SpeedW-1:0]      speed_q;
  logic signed [ehss_pkg::PosW-1:0] pos_q;
  ehss_pkg::phase_e                 ph_out_q;

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = pop_o || (out_valid_q && !out_ready_i);

  // Saturating edge count.
  always_comb begin
    count_e = count_q;
    if (ev_i.edge_up && (count_q != ehss_pkg::PosMax)) begin
      count_e = count_q + 16'sd1;
    end else if (ev_i.edge_down && (count_q != ehss_pkg::PosMin)) begin
      count_e = count_q - 16'sd1;
    end
  end

  assign home_s     = $signed({1'b0, cfg_i.home_offset});
  assign limit_s    = $signed({1'b0, cfg_i.stroke_limit});
  assign pause_done = (pause_q <= ehss_pkg::PauseW'(1));

  // Next phase, count and pause counter.
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    pause_d = pause_q;
    if (pop_o) begin
      count_d = count_e;
      unique case (phase_q)
        ehss_pkg::PH_TO_START: begin
          if (count_e >= home_s) begin
            phase_d = ehss_pkg::PH_HOME_PAUSE;
            pause_d = cfg_i.pause_ticks;
          end
        end
        ehss_pkg::PH_HOME_PAUSE: begin
          if (pause_done) begin
            count_d = '0;
            phase_d = ehss_pkg::PH_FORWARD;
          end else begin
            pause_d = pause_q - 1'b1;
          end
        end
        ehss_pkg::PH_FORWARD: begin
          if (count_e > limit_s) begin
            phase_d = ehss_pkg::PH_FWD_PAUSE;
            pause_d = cfg_i.pause_ticks;
          end
        end
        ehss_pkg::PH_FWD_PAUSE: begin
          if (pause_done) begin
            phase_d = ehss_pkg::PH_BACKWARD;
          end else begin
            pause_d = pause_q - 1'b1;
          end
        end
        ehss_pkg::PH_BACKWARD: begin
          if (count_e <= 16'sd0) begin
            phase_d = ehss_pkg::PH_BWD_PAUSE;
            pause_d = cfg_i.pause_ticks;
          end
        end
        ehss_pkg::PH_BWD_PAUSE: begin
          if (pause_done) begin
            phase_d = ehss_pkg::PH_FORWARD;
          end else begin
            pause_d = pause_q - 1'b1;
          end
        end
        default: begin
          phase_d = ev_i.index_hit ? ehss_pkg::PH_TO_START : ehss_pkg::PH_SEEK;
        end
      endcase
    end
  end

  // Motor command of the phase after this item's transition.
  always_comb begin
    unique case (phase_d)
      ehss_pkg::PH_HOME_PAUSE, ehss_pkg::PH_FWD_PAUSE, ehss_pkg::PH_BWD_PAUSE: begin
        cmd_d   = ehss_pkg::CMD_RELEASE;
        speed_d = '0;
      end
      ehss_pkg::PH_BACKWARD: begin
        cmd_d   = ehss_pkg::CMD_BACKWARD;
        speed_d = cfg_i.backward_speed;
      end
      default: begin
        cmd_d   = ehss_pkg::CMD_FORWARD;
        speed_d = cfg_i.forward_speed;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pause_q     <= '0;
      phase_q     <= ehss_pkg::PH_SEEK;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pause_q     <= pause_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q    <= cmd_d;
      speed_q  <= speed_d;
      pos_q    <= count_d;
      ph_out_q <= phase_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign motor_cmd_o   = cmd_q;
  assign motor_speed_o = speed_q;
  assign position_o    = pos_q;
  assign phase_o       = ph_out_q;

endmodule

### sv/encoder_homing_stroke_sequencer_top.sv
// Top level of the encoder homing stroke sequencer: registers, front, queue, back.
//
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   chan_a_i, chan_b_i, index_pin_i
// out       output     out_valid_o / out_ready_i motor_cmd_o, motor_speed_o,
//                                                position_o, phase_o
// cfg       input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One item is accepted per cycle while the queue is not full; its result item
// passes through the item queue and then the output register.
// The rate is set by the update of the position counter and sequencer
// state in the back end, which takes one queued item each cycle unless the output is stalled.
// Reset clears the counter, the sequencer and the queue, and loads the
// configuration registers with their default values.
// While the output is stalled, the queue absorbs up to QueueDepth items;
// in_ready_o drops only when the queue is full.
module encoder_homing_stroke_sequencer_top #(
  parameter int QueueDepth = ehss_pkg::QueueDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ehss_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ehss_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 chan_a_i,
  input  logic                                 chan_b_i,
  input  logic                                 index_pin_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           motor_cmd_o,
  output logic [ehss_pkg::SpeedW-1:0]          motor_speed_o,
  output logic signed [ehss_pkg::PosW-1:0]     position_o,
  output logic [2:0]                           phase_o
);

  ehss_pkg::cfg_t cfg_q, cfg_d;
  ehss_pkg::ev_t  front_ev, head_ev;
  logic           push, pop, q_full, q_valid;

  // Configuration registers. Writes to an index beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ehss_pkg::CFG_HOME_OFFSET:    cfg_d.home_offset    = cfg_data_i[ehss_pkg::OffsetW-1:0];
        ehss_pkg::CFG_STROKE_LIMIT:   cfg_d.stroke_limit   = cfg_data_i[ehss_pkg::OffsetW-1:0];
        ehss_pkg::CFG_FORWARD_SPEED:  cfg_d.forward_speed  = cfg_data_i[ehss_pkg::SpeedW-1:0];
        ehss_pkg::CFG_BACKWARD_SPEED: cfg_d.backward_speed = cfg_data_i[ehss_pkg::SpeedW-1:0];
        ehss_pkg::CFG_PAUSE_TICKS:    cfg_d.pause_ticks    = cfg_data_i[ehss_pkg::PauseW-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_offset    <= ehss_pkg::HomeOffsetReset;
      cfg_q.stroke_limit   <= ehss_pkg::StrokeLimitReset;
      cfg_q.forward_speed  <= ehss_pkg::ForwardSpeedReset;
      cfg_q.backward_speed <= ehss_pkg::BackwardSpeedReset;
      cfg_q.pause_ticks    <= ehss_pkg::PauseTicksReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end decodes the A edge as soon as an item arrives, so the
  // back end only sees count-up, count-down and index flags.
  ehss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .chan_a_i    (chan_a_i),
    .chan_b_i    (chan_b_i),
    .index_pin_i (index_pin_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .ev_o        (front_ev)
  );

  ehss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_ev),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .head_o      (head_ev)
  );

  // The back end updates the count and phase and registers one result item
  // per queued item, holding it while the output is stalled.
  ehss_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .ev_i          (head_ev),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .motor_cmd_o   (motor_cmd_o),
    .motor_speed_o (motor_speed_o),
    .position_o    (position_o),
    .phase_o       (phase_o)
  );

endmodule

### sim/encoder_homing_stroke_sequencer_top_test.sv
// Self-checking testbench of the encoder homing stroke sequencer top level.
`timescale 1ns / 100ps

module encoder_homing_stroke_sequencer_top_test;
  import ehss_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int ResetCycles = 6;
  // The run limit lies well above the slowest correct run.
  localparam int RunLimitNs = 400_000 * 2 * HalfPeriod;
  localparam int HoldCycles = 60;
  localparam int DrainLimit = 1000;
  localparam int RandomPhases = 6;
  localparam int ItemsPerPhase = 190;
  localparam int SweepTicks = 100;

  // What the block reports for one sample tick.
  typedef struct packed {
    cmd_e                   cmd;
    logic [SpeedW-1:0]      speed;
    logic signed [PosW-1:0] pos;
    phase_e                 phase;
  } drive_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [CfgDataW-1:0]    cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   chan_a_i = 1'b0;
  logic                   chan_b_i = 1'b0;
  logic                   index_pin_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [1:0]             motor_cmd_o;
  logic [SpeedW-1:0]      motor_speed_o;
  logic signed [PosW-1:0] position_o;
  logic [2:0]             phase_o;

  encoder_homing_stroke_sequencer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .chan_a_i     (chan_a_i),
    .chan_b_i     (chan_b_i),
    .index_pin_i  (index_pin_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .motor_cmd_o  (motor_cmd_o),
    .motor_speed_o(motor_speed_o),
    .position_o   (position_o),
    .phase_o      (phase_o)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers, loaded with their reset values.
  logic [OffsetW-1:0] home_offset_q    = HomeOffsetReset;
  logic [OffsetW-1:0] stroke_limit_q   = StrokeLimitReset;
  logic [SpeedW-1:0]  forward_speed_q  = ForwardSpeedReset;
  logic [SpeedW-1:0]  backward_speed_q = BackwardSpeedReset;
  logic [PauseW-1:0]  pause_ticks_q    = PauseTicksReset;

  // Shadow copy of the counter and sequencer state.
  logic signed [PosW-1:0] count_q      = '0;
  logic                   last_a_q     = 1'b0;
  phase_e                 phase_q      = PH_SEEK;
  logic [PauseW-1:0]      pause_left_q = '0;

  drive_result_t expected_drive_q [$];
  int            fault_count = 0;

  // Pacing controls shared by the stimulus and the receiver.
  bit quiet_tail   = 1'b0;
  bit hold_request = 1'b0;
  bit hold_active  = 1'b0;

  // Quadrature step of the simulated motor shaft, 0 to 3 in Gray order.
  int shaft_step = 0;

  function automatic void store_setting(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_HOME_OFFSET:    home_offset_q    = data[OffsetW-1:0];
      CFG_STROKE_LIMIT:   stroke_limit_q   = data[OffsetW-1:0];
      CFG_FORWARD_SPEED:  forward_speed_q  = data[SpeedW-1:0];
      CFG_BACKWARD_SPEED: backward_speed_q = data[SpeedW-1:0];
      CFG_PAUSE_TICKS:    pause_ticks_q    = data[PauseW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void enter_pause(input phase_e next);
    phase_q      = next;
    pause_left_q = pause_ticks_q;
  endfunction

  // Counts one pause tick down; true once the pause is over.
  function automatic bit pause_over();
    if (pause_left_q > 1) begin
      pause_left_q = pause_left_q - 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Decodes one sample tick, advances the sequencer and returns the motor drive.
  function automatic drive_result_t advance_sequencer(input logic a, b, idx);
    drive_result_t r;
    // x1 decoding: only a rising edge of A moves the count, B gives the direction.
    if (!last_a_q && a) begin
      if (!b) begin
        if (count_q != PosMax) count_q = count_q + 16'sd1;
      end else if (count_q != PosMin) begin
        count_q = count_q - 16'sd1;
      end
    end
    last_a_q = a;

    case (phase_q)
      PH_TO_START: if (int'(count_q) >= int'(home_offset_q)) enter_pause(PH_HOME_PAUSE);
      PH_HOME_PAUSE: begin
        if (pause_over()) begin
          count_q = '0;
          phase_q = PH_FORWARD;
        end
      end
      PH_FORWARD: if (int'(count_q) > int'(stroke_limit_q)) enter_pause(PH_FWD_PAUSE);
      PH_FWD_PAUSE: if (pause_over()) phase_q = PH_BACKWARD;
      PH_BACKWARD: if (int'(count_q) <= 0) enter_pause(PH_BWD_PAUSE);
      PH_BWD_PAUSE: if (pause_over()) phase_q = PH_FORWARD;
      default: phase_q = idx ? PH_TO_START : PH_SEEK;
    endcase

    case (phase_q)
      PH_SEEK, PH_TO_START, PH_FORWARD: begin
        r.cmd   = CMD_FORWARD;
        r.speed = forward_speed_q;
      end
      PH_BACKWARD: begin
        r.cmd   = CMD_BACKWARD;
        r.speed = backward_speed_q;
      end
      default: begin
        r.cmd   = CMD_RELEASE;
        r.speed = '0;
      end
    endcase
    r.pos   = count_q;
    r.phase = phase_q;
    return r;
  endfunction

  // Offers one sample tick and records its expected drive once it is taken.
  // Valid is left high on return: the caller either offers the next tick or
  // lowers valid in the same time step.
  task automatic send_tick(input logic a, b, idx);
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    chan_a_i    <= a;
    chan_b_i    <= b;
    index_pin_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    expected_drive_q.push_back(advance_sequencer(a, b, idx));
  endtask

  // Sends n full A cycles with B held, so each cycle makes one rising edge.
  task automatic send_edges(input logic b, input int n);
    for (int i = 0; i < n; i++) begin
      send_tick(1'b1, b, 1'b0);
      send_tick(1'b0, b, 1'b0);
    end
  endtask

  // One tick of a shaft that follows the motor command, with some glitches.
  task automatic motor_tick();
    int   step;
    logic a, b, idx;
    step = 0;
    case (phase_q)
      PH_SEEK, PH_TO_START, PH_FORWARD: if ($urandom_range(0, 3) != 0) step = 1;
      PH_BACKWARD: if ($urandom_range(0, 3) != 0) step = -1;
      // A released shaft drifts now and then.
      default: if ($urandom_range(0, 7) == 0) step = $urandom_range(0, 1) ? 1 : -1;
    endcase
    shaft_step = (shaft_step + step) & 3;
    a   = (shaft_step == 1) || (shaft_step == 2);
    b   = (shaft_step >= 2);
    idx = (phase_q == PH_SEEK) ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 31) == 0);
    if ($urandom_range(0, 15) == 0) {a, b, idx} = 3'($urandom);
    send_tick(a, b, idx);
  endtask

  // Toggles A every tick with B fixed: an edge on every second tick.
  task automatic sweep_tick(input logic down);
    send_tick(!last_a_q, down, 1'($urandom));
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all registers, with random bits above the offset and speed widths, after a write
  // to an unused index that must change nothing.
  task automatic write_regs(input logic [OffsetW-1:0] home, stroke,
                            input logic [SpeedW-1:0] fwd, bwd,
                            input logic [PauseW-1:0] pause_len);
    logic [CfgDataW-1:0] vals [5];
    logic [CfgIdxW-1:0]  unused_idx;
    vals[CFG_HOME_OFFSET]    = {1'($urandom), home};
    vals[CFG_STROKE_LIMIT]   = {1'($urandom), stroke};
    vals[CFG_FORWARD_SPEED]  = {8'($urandom), fwd};
    vals[CFG_BACKWARD_SPEED] = {8'($urandom), bwd};
    vals[CFG_PAUSE_TICKS]    = pause_len;
    unused_idx = CfgIdxW'($urandom_range(int'(CFG_PAUSE_TICKS) + 1, (1 << CfgIdxW) - 1));
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= unused_idx;
    cfg_data_i <= CfgDataW'($urandom);
    @(posedge clk_i);
    store_setting(unused_idx, cfg_data_i);
    for (int i = 0; i <= int'(CFG_PAUSE_TICKS); i++) begin
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      store_setting(CfgIdxW'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Defaults while seeking, then one walk through every phase with
  // small offsets, no pause and the speed extremes.
  task automatic test_homing_walk();
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    wait_drained();
    write_regs(15'd3, 15'd2, 8'd255, 8'd0, 16'd0);
    // Index seen, then rising edges of A bring the count to the start, and a zero pause follows.
    send_tick(1'b0, 1'b0, 1'b1);
    send_edges(1'b0, 3);
    // The count then passes the stroke limit, and the shaft runs back to zero.
    send_edges(1'b0, 3);
    send_edges(1'b1, 3);
  endtask

  // Shaft-following stimulus under several settings, the extremes first.
  task automatic test_random_strokes();
    for (int s = 0; s < RandomPhases; s++) begin
      wait_drained();
      case (s)
        0: write_regs(15'd0, 15'd0, 8'd0, 8'd255, 16'd0);
        1: write_regs(15'd1, 15'd1, 8'd255, 8'd0, 16'd1);
        default: write_regs(OffsetW'($urandom_range(0, 12)), OffsetW'($urandom_range(0, 20)),
                            8'($urandom), 8'($urandom), PauseW'($urandom_range(0, 10)));
      endcase
      repeat (ItemsPerPhase) motor_tick();
    end
  endtask

  // The receiver holds off while ticks keep coming, so the queue fills and
  // the input must stall without losing or repeating an item.
  task automatic test_output_backpressure();
    in_valid_i   <= 1'b0;
    hold_request = 1'b1;
    while (!hold_active) @(posedge clk_i);
    repeat (30) motor_tick();
  endtask

  // With the stroke limit at its top the forward stroke does not end, so the
  // count keeps climbing with the fastest forward speed on the outputs.
  task automatic test_top_stroke_limit();
    wait_drained();
    write_regs(15'd0, 15'h7FFF, 8'd255, 8'd255, 16'd0);
    while (phase_q != PH_FORWARD) motor_tick();
    repeat (SweepTicks) sweep_tick(1'b0);
  endtask

  // A zero stroke limit ends the forward stroke at once and loads the longest
  // pause, which keeps the motor released while the shaft turns backward.
  task automatic test_long_pause();
    wait_drained();
    write_regs(15'h7FFF, 15'd0, 8'd255, 8'd255, 16'hFFFF);
    repeat (SweepTicks) sweep_tick(1'b1);
  endtask

  initial begin : run_tests
    int waited;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_homing_walk();
    test_random_strokes();
    test_output_backpressure();
    // From here on neither side idles.
    quiet_tail = 1'b1;
    test_top_stroke_limit();
    test_long_pause();
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_drive_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_drive_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_drive_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver pacing: ready bursts, random stalls, and one long hold on request.
  initial begin : sink_pacing
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_request) begin
        hold_active = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active  = 1'b0;
        hold_request = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Every result item taken by the receiver is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    drive_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_drive_q.size() == 0) begin
        $error("result item arrived with no tick waiting for it");
        fault_count++;
      end else begin
        want = expected_drive_q.pop_front();
        if (motor_cmd_o !== want.cmd) begin
          $error("motor_cmd: expected %0d, got %0d", want.cmd, motor_cmd_o);
          fault_count++;
        end
        if (motor_speed_o !== want.speed) begin
          $error("motor_speed: expected %0d, got %0d", want.speed, motor_speed_o);
          fault_count++;
        end
        if (position_o !== want.pos) begin
          $error("position: expected %0d, got %0d", $signed(want.pos), position_o);
          fault_count++;
        end
        if (phase_o !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, phase_o);
          fault_count++;
        end
      end
    end
  end

  initial begin : run_limit
    #(RunLimitNs);
    $display("Some tests failed");
    $finish;
  end

endmodule

### encoder_homing_stroke_sequencer_top.f
sv/ehss_pkg.sv
sv/ehss_front.sv
sv/ehss_queue.sv
sv/ehss_back.sv
sv/encoder_homing_stroke_sequencer_top.sv
sim/encoder_homing_stroke_sequencer_top_test.sv
